[src/tle_pkg.sv]
package tle_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_BACKSPACE = 8'd8;

    // result destinations
    localparam logic DEST_ECHO   = 1'b0;
    localparam logic DEST_READER = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CANONICAL_MODE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ECHO_ENABLE    = 1'b1;

endpackage

[src/tle_ifs.sv]
interface tle_byte_if;
    logic                         valid;
    logic                         ready;
    logic [tle_pkg::BYTE_W-1:0]   byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface tle_result_if;
    logic                         valid;
    logic                         ready;
    logic                         destination;
    logic [tle_pkg::BYTE_W-1:0]   data_byte;
    logic                         last;

    modport source (output valid, output destination, output data_byte, output last,
                    input ready);
    modport sink   (input valid, input destination, input data_byte, input last,
                    output ready);
endinterface

interface tle_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tle_pkg::CFG_INDEX_W-1:0]    index;
    logic                               data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/tle_line_ram.sv]
module tle_line_ram #(
    parameter int unsigned DEPTH  = 32,
    parameter int unsigned ADDR_W = 5
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [tle_pkg::BYTE_W-1:0]  wdata,
    input  logic                        re,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [tle_pkg::BYTE_W-1:0]  rdata
);

    logic [tle_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [tle_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/terminal_line_editor_core.sv]
// Terminal line editor: canonical line discipline for typed bytes.
//
// byte_chan carries one typed byte per item; result_chan carries the results
// (destination, data_byte, last), and last marks the final result of an item.
// cfg writes canonical_mode (index 0) and echo_enable (index 1); it is always
// ready and is meant to be written only while the block is idle.
//
// Raw bytes, ordinary bytes and backspaces are accepted directly and their
// result, if any, is valid on the following cycle. A newline starts a
// readout of the stored line from the line RAM: each stored byte is read
// from the RAM, then loaded into the output register, and byte_chan stays
// not ready until the readout of the whole line has ended. The output
// register holds one result; a stalled receiver holds the readout, and a
// new item is taken only when the output register is free or being
// emptied in the same cycle.
//
// Reset clears the line length to zero and sets both registers to 1. The line
// RAM is not cleared; only entries up to the length (where the newline goes) are read.
module terminal_line_editor_core #(
    parameter int unsigned LINE_BYTES = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    tle_byte_if.sink             byte_chan,
    tle_result_if.source         result_chan,
    tle_cfg_if.sink              cfg
);

    localparam int unsigned ADDR_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam logic [ADDR_W-1:0] LEN_MAX = ADDR_W'(LINE_BYTES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } state_t;

    state_t                       state_reg, state_next;
    logic [ADDR_W-1:0]            line_length_reg, line_length_next;
    logic [ADDR_W-1:0]            rd_idx_reg, rd_idx_next;
    logic [ADDR_W-1:0]            end_idx_reg, end_idx_next;
    logic                         canonical_reg, canonical_next;
    logic                         echo_reg, echo_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         destination_reg, destination_next;
    logic [tle_pkg::BYTE_W-1:0]   data_reg, data_next;
    logic                         last_reg, last_next;

    logic                         out_free;
    logic                         accept;
    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    logic                         ram_re;
    logic [tle_pkg::BYTE_W-1:0]   ram_rdata;
    logic [tle_pkg::BYTE_W-1:0]   b;

    tle_line_ram #(
        .DEPTH  (LINE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (b),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign b        = byte_chan.byte_in;
    assign out_free = !out_valid_reg || result_chan.ready;
    assign byte_chan.ready = (state_reg == S_IDLE) && out_free;
    assign accept   = byte_chan.valid && byte_chan.ready;
    assign cfg.ready = 1'b1;

    assign result_chan.valid       = out_valid_reg;
    assign result_chan.destination = destination_reg;
    assign result_chan.data_byte   = data_reg;
    assign result_chan.last        = last_reg;

    always_comb
    begin
        state_next       = state_reg;
        line_length_next = line_length_reg;
        rd_idx_next      = rd_idx_reg;
        end_idx_next     = end_idx_reg;
        canonical_next   = canonical_reg;
        echo_next        = echo_reg;
        out_valid_next   = out_valid_reg && !result_chan.ready;
        destination_next = destination_reg;
        data_next        = data_reg;
        last_next        = last_reg;
        ram_we           = 1'b0;
        ram_waddr        = line_length_reg;
        ram_re           = 1'b0;

        if (cfg.valid)
        begin
            case (cfg.index)
                tle_pkg::CFG_CANONICAL_MODE: canonical_next = cfg.data;
                tle_pkg::CFG_ECHO_ENABLE:    echo_next      = cfg.data;
                default:                     ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!canonical_reg)
                    begin
                        out_valid_next   = 1'b1;
                        destination_next = tle_pkg::DEST_READER;
                        data_next        = b;
                        last_next        = 1'b1;
                    end
                    else if (b == tle_pkg::CHAR_NEWLINE)
                    begin
                        ram_we           = 1'b1;
                        end_idx_next     = line_length_reg;
                        rd_idx_next      = '0;
                        line_length_next = '0;
                        state_next       = S_READ;
                        if (echo_reg)
                        begin
                            out_valid_next   = 1'b1;
                            destination_next = tle_pkg::DEST_ECHO;
                            data_next        = b;
                            last_next        = 1'b0;
                        end
                    end
                    else if (b == tle_pkg::CHAR_BACKSPACE)
                    begin
                        if (line_length_reg != '0)
                        begin
                            line_length_next = line_length_reg - 1'b1;
                            if (echo_reg)
                            begin
                                out_valid_next   = 1'b1;
                                destination_next = tle_pkg::DEST_ECHO;
                                data_next        = b;
                                last_next        = 1'b1;
                            end
                        end
                    end
                    // full line: byte dropped without a result
                    else if (line_length_reg != LEN_MAX)
                    begin
                        ram_we           = 1'b1;
                        line_length_next = line_length_reg + 1'b1;
                        if (echo_reg)
                        begin
                            out_valid_next   = 1'b1;
                            destination_next = tle_pkg::DEST_ECHO;
                            data_next        = b;
                            last_next        = 1'b1;
                        end
                    end
                end
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    destination_next = tle_pkg::DEST_READER;
                    data_next        = ram_rdata;
                    last_next        = (rd_idx_reg == end_idx_reg);
                    if (rd_idx_reg == end_idx_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            line_length_reg <= '0;
            rd_idx_reg      <= '0;
            end_idx_reg     <= '0;
            canonical_reg   <= 1'b1;
            echo_reg        <= 1'b1;
            out_valid_reg   <= 1'b0;
            destination_reg <= 1'b0;
            data_reg        <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            line_length_reg <= line_length_next;
            rd_idx_reg      <= rd_idx_next;
            end_idx_reg     <= end_idx_next;
            canonical_reg   <= canonical_next;
            echo_reg        <= echo_next;
            out_valid_reg   <= out_valid_next;
            destination_reg <= destination_next;
            data_reg        <= data_next;
            last_reg        <= last_next;
        end
    end

    a_length_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_length_reg <= LEN_MAX)
        else $error("line length beyond capacity");

    a_newline_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && canonical_reg && (b == tle_pkg::CHAR_NEWLINE))
        |=> (line_length_reg == '0) && (state_reg == S_READ))
        else $error("newline did not clear line and start readout");

    a_readout_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (rd_idx_reg <= end_idx_reg))
        else $error("readout index past end of line");

endmodule
